FILE: rtl/dlst_pkg.sv
// Package for the delta-list sleep timer: payload structs, result kinds and
// the front-to-back command type. No dependencies.
`default_nettype none
package dlst_pkg;
    localparam int unsigned TPS_W = 10;
    localparam int unsigned PID_W = 8;
    localparam int unsigned SECS_W = 16;

    typedef enum logic [1:0] {
        KIND_TIME   = 2'd0,
        KIND_WAKE   = 2'd1,
        KIND_ACCEPT = 2'd2,
        KIND_REJECT = 2'd3
    } t_kind;

    typedef enum logic {
        OP_TICK   = 1'b0,
        OP_INSERT = 1'b1
    } t_op;

    typedef struct packed {
        logic              operation;
        logic [PID_W-1:0]  requester_id;
        logic [SECS_W-1:0] sleep_seconds;
    } t_in_item;

    typedef struct packed {
        logic [1:0]       kind;
        logic [PID_W-1:0] process_id;
        logic [4:0]       hours;
        logic [5:0]       minutes;
        logic [5:0]       seconds;
        logic             last;
    } t_out_item;

    // Classified command handed from the front to the back.
    typedef struct packed {
        logic              is_insert;
        logic              second_done;
        logic [PID_W-1:0]  owner;
        logic [SECS_W-1:0] secs;
        logic [4:0]        hours;
        logic [5:0]        minutes;
        logic [5:0]        seconds;
    } t_cmd;
endpackage
`default_nettype wire

FILE: rtl/dlst_front.sv
// Front part: accepts input transactions, runs the tick prescaler and the
// time-of-day clock, and pushes classified commands. Depends on dlst_pkg.
`default_nettype none
module dlst_front (
    input  wire               i_clk,
    input  wire               i_rst_n,
    input  wire               i_cfg_valid,
    output logic              o_cfg_ready,
    input  wire [9:0]         i_cfg_data,
    input  wire               i_valid,
    output logic              o_ready,
    input  wire dlst_pkg::t_in_item i_data,
    output logic              o_cmd_valid,
    input  wire               i_cmd_ready,
    output dlst_pkg::t_cmd    o_cmd
);
    import dlst_pkg::*;

    logic [9:0] r_tps, r_tick;
    logic [4:0] r_hh;
    logic [5:0] r_mm, r_ss;
    logic [9:0] n_tick;
    logic [4:0] n_hh;
    logic [5:0] n_mm, n_ss;
    logic       done;

    assign o_cfg_ready = 1'b1;
    assign o_ready     = i_cmd_ready;
    assign o_cmd_valid = i_valid;

    always_comb begin
        n_tick = r_tick + 10'd1;
        done   = ({1'b0, n_tick} >= {1'b0, r_tps});
        n_ss = r_ss; n_mm = r_mm; n_hh = r_hh;
        if (done) begin
            n_tick = '0;
            if (r_ss == 6'd59) begin
                n_ss = '0;
                if (r_mm == 6'd59) begin
                    n_mm = '0;
                    n_hh = (r_hh == 5'd23) ? 5'd0 : r_hh + 5'd1;
                end else begin
                    n_mm = r_mm + 6'd1;
                end
            end else begin
                n_ss = r_ss + 6'd1;
            end
        end
        o_cmd.is_insert   = (i_data.operation == OP_INSERT);
        o_cmd.second_done = done && !o_cmd.is_insert;
        o_cmd.owner       = i_data.requester_id;
        o_cmd.secs        = i_data.sleep_seconds;
        o_cmd.hours   = o_cmd.second_done ? n_hh : r_hh;
        o_cmd.minutes = o_cmd.second_done ? n_mm : r_mm;
        o_cmd.seconds = o_cmd.second_done ? n_ss : r_ss;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tps <= 10'd60; r_tick <= '0; r_hh <= '0; r_mm <= '0; r_ss <= '0;
        end else begin
            if (i_cfg_valid) r_tps <= i_cfg_data;
            if (i_valid && i_cmd_ready && i_data.operation == OP_TICK) begin
                r_tick <= n_tick; r_ss <= n_ss; r_mm <= n_mm; r_hh <= n_hh;
            end
        end
    end
endmodule
`default_nettype wire

FILE: rtl/dlst_fifo.sv
// Two-entry command queue between the front and back parts.
// Depends on dlst_pkg.
`default_nettype none
module dlst_fifo (
    input  wire            i_clk,
    input  wire            i_rst_n,
    input  wire            i_valid,
    output logic           o_ready,
    input  wire dlst_pkg::t_cmd i_data,
    output logic           o_valid,
    input  wire            i_ready,
    output dlst_pkg::t_cmd o_data
);
    import dlst_pkg::*;
    t_cmd       r_mem [2];
    logic       r_wp, r_rp;
    logic [1:0] r_cnt;
    logic       push, pop;

    assign o_ready = (r_cnt != 2'd2);
    assign o_valid = (r_cnt != 2'd0);
    assign o_data  = r_mem[r_rp];
    assign push = i_valid && o_ready;
    assign pop  = o_valid && i_ready;

    always_ff @(posedge i_clk) begin
        if (push) r_mem[r_wp] <= i_data;
        if (!i_rst_n) begin
            r_wp <= 1'b0; r_rp <= 1'b0; r_cnt <= '0;
        end else begin
            if (push) r_wp <= ~r_wp;
            if (pop)  r_rp <= ~r_rp;
            r_cnt <= r_cnt + {1'b0, push} - {1'b0, pop};
        end
    end
endmodule
`default_nettype wire

FILE: rtl/dlst_back.sv
// Back part: sequencer over the slot tables that splices inserts into the
// delta list and wakes due sleepers. Depends on dlst_pkg.
`default_nettype none
module dlst_back #(
    parameter int unsigned N  = 16,
    parameter int unsigned AW = $clog2(N + 1)
) (
    input  wire                i_clk,
    input  wire                i_rst_n,
    input  wire                i_cmd_valid,
    output logic               o_cmd_ready,
    input  wire dlst_pkg::t_cmd i_cmd,
    output logic               o_valid,
    input  wire                i_ready,
    output dlst_pkg::t_out_item o_data
);
    import dlst_pkg::*;

    localparam logic [AW-1:0] NULL = AW'(N);

    typedef enum logic [5:0] {
        S_IDLE = 6'b000001,
        S_WALK = 6'b000010,
        S_LINK = 6'b000100,
        S_WAKE = 6'b001000,
        S_EMIT = 6'b010000,
        S_OUT  = 6'b100000
    } t_state;

    logic [SECS_W-1:0] r_delta [N];
    logic [PID_W-1:0]  r_owner [N];
    logic [AW-1:0]     r_link  [N];
    logic [N-1:0]      r_lvalid;
    logic [AW-1:0]     r_qhead, r_fhead;
    t_state            r_state;
    t_cmd              r_cmd;
    logic [AW-1:0]     r_slot, r_prev, r_p;
    logic [SECS_W-1:0] r_rem;
    logic [AW:0]       r_guard;
    logic              r_first;
    t_out_item         r_out;
    logic              r_ovalid;

    // Links are read through valid bits: an unwritten link is the reset chain.
    function automatic logic [AW-1:0] link_of(input logic [AW-1:0] s,
            input logic v, input logic [AW-1:0] l);
        link_of = v ? l : AW'(s + AW'(1));
    endfunction

    logic [$clog2(N)-1:0] pi, hi;
    logic [AW-1:0]        p_link, h_link;
    logic                 hd_zero;
    logic                 emit;
    assign pi = r_p[$clog2(N)-1:0];
    assign hi = r_qhead[$clog2(N)-1:0];
    assign p_link = link_of(r_p, r_lvalid[pi], r_link[pi]);
    assign h_link = link_of(r_qhead, r_lvalid[hi], r_link[hi]);
    assign hd_zero = (r_delta[hi] == '0);

    // A result is loaded into the output register in this cycle.
    assign emit = (!r_ovalid || i_ready) &&
            ((r_state == S_WAKE && r_qhead != NULL && r_guard < (AW+1)'(N) && hd_zero)
            || r_state == S_EMIT || r_state == S_OUT);

    // A new command is taken only when the output register is free, so a
    // waiting result never has its payload changed.
    assign o_cmd_ready = (r_state == S_IDLE) && (!r_ovalid || i_ready);
    assign o_valid = r_ovalid;
    assign o_data  = r_out;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE; r_lvalid <= '0; r_qhead <= NULL; r_fhead <= '0;
            r_ovalid <= 1'b0;
        end else begin
            if (emit) r_ovalid <= 1'b1;
            else if (i_ready) r_ovalid <= 1'b0;
            unique case (r_state)
                S_IDLE: begin
                    if (i_cmd_valid && (!r_ovalid || i_ready)) begin
                        r_cmd <= i_cmd;
                        r_out.hours <= i_cmd.hours;
                        r_out.minutes <= i_cmd.minutes;
                        r_out.seconds <= i_cmd.seconds;
                        r_out.last <= 1'b1;
                        r_guard <= '0;
                        r_first <= 1'b1;
                        if (i_cmd.is_insert) begin
                            r_out.process_id <= i_cmd.owner;
                            if (r_fhead == NULL) begin
                                r_out.kind <= KIND_REJECT;
                                r_state <= S_OUT;
                            end else begin
                                r_slot <= r_fhead;
                                r_prev <= NULL;
                                r_p <= r_qhead;
                                r_rem <= i_cmd.secs;
                                r_state <= S_WALK;
                            end
                        end else if (i_cmd.second_done && r_qhead != NULL) begin
                            r_state <= S_WAKE;
                        end else begin
                            r_out.kind <= KIND_TIME;
                            r_out.process_id <= '0;
                            r_state <= S_OUT;
                        end
                    end
                end
                S_WALK: begin
                    if (r_p != NULL && r_guard < (AW+1)'(N)
                            && r_rem >= r_delta[pi]) begin
                        r_rem <= r_rem - r_delta[pi];
                        r_prev <= r_p;
                        r_p <= p_link;
                        r_guard <= r_guard + 1'b1;
                    end else begin
                        r_fhead <= link_of(r_slot, r_lvalid[r_slot[$clog2(N)-1:0]],
                                r_link[r_slot[$clog2(N)-1:0]]);
                        if (r_p != NULL) r_delta[pi] <= r_delta[pi] - r_rem;
                        r_state <= S_LINK;
                    end
                end
                S_LINK: begin
                    r_delta[r_slot[$clog2(N)-1:0]] <= r_rem;
                    r_owner[r_slot[$clog2(N)-1:0]] <= r_cmd.owner;
                    r_link[r_slot[$clog2(N)-1:0]] <= r_p;
                    r_lvalid[r_slot[$clog2(N)-1:0]] <= 1'b1;
                    if (r_prev == NULL) begin
                        r_qhead <= r_slot;
                    end else begin
                        r_link[r_prev[$clog2(N)-1:0]] <= r_slot;
                        r_lvalid[r_prev[$clog2(N)-1:0]] <= 1'b1;
                    end
                    r_out.kind <= KIND_ACCEPT;
                    r_state <= S_OUT;
                end
                S_WAKE: begin
                    if (r_first && !hd_zero) begin
                        r_delta[hi] <= r_delta[hi] - 1'b1;
                        r_first <= 1'b0;
                    end else if (r_qhead != NULL && r_guard < (AW+1)'(N) && hd_zero) begin
                        if (!r_ovalid || i_ready) begin
                            r_out.kind <= KIND_WAKE;
                            r_out.process_id <= r_owner[hi];
                            r_out.last <= 1'b0;
                            r_qhead <= h_link;
                            r_link[hi] <= r_fhead;
                            r_lvalid[hi] <= 1'b1;
                            r_fhead <= r_qhead;
                            r_guard <= r_guard + 1'b1;
                            r_first <= 1'b0;
                        end
                    end else begin
                        r_state <= S_EMIT;
                    end
                end
                S_EMIT: begin
                    if (!r_ovalid || i_ready) begin
                        r_out.kind <= KIND_TIME;
                        r_out.process_id <= '0;
                        r_out.last <= 1'b1;
                        r_state <= S_IDLE;
                    end
                end
                S_OUT: begin
                    if (!r_ovalid || i_ready) begin
                        r_state <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end
endmodule
`default_nettype wire

FILE: rtl/delta_list_sleep_timer_core.sv
// Delta-list sleep timer top level: front (prescaler, clock), command queue,
// back (slot sequencer). The back sequencer steps one slot per cycle, holding
// a wakeup while the output is not taken, and takes a new command only once
// it has finished the last one. Synchronous active-low reset restores the
// free chain, empties the queue and sets the clock to zero.
`default_nettype none
module delta_list_sleep_timer_core #(
    parameter int unsigned MAX_SLEEPERS = 16
) (
    input  wire                 i_clk,
    input  wire                 i_rst_n,
    input  wire                 i_cfg_valid,
    output logic                o_cfg_ready,
    input  wire [9:0]           i_cfg_data,
    input  wire                 i_valid,
    output logic                o_ready,
    input  wire dlst_pkg::t_in_item i_data,
    output logic                o_valid,
    input  wire                 i_ready,
    output dlst_pkg::t_out_item o_data
);
    import dlst_pkg::*;

    // Commands travel front to queue to back; each transaction is one item.
    t_cmd f_cmd, q_cmd;
    logic f_valid, f_ready, q_valid, q_ready;

    dlst_front u_front (
        .i_clk, .i_rst_n, .i_cfg_valid, .o_cfg_ready, .i_cfg_data,
        .i_valid, .o_ready, .i_data,
        .o_cmd_valid(f_valid), .i_cmd_ready(f_ready), .o_cmd(f_cmd)
    );

    dlst_fifo u_fifo (
        .i_clk, .i_rst_n,
        .i_valid(f_valid), .o_ready(f_ready), .i_data(f_cmd),
        .o_valid(q_valid), .i_ready(q_ready), .o_data(q_cmd)
    );

    dlst_back #(.N(MAX_SLEEPERS)) u_back (
        .i_clk, .i_rst_n,
        .i_cmd_valid(q_valid), .o_cmd_ready(q_ready), .i_cmd(q_cmd),
        .o_valid, .i_ready, .o_data
    );
endmodule
`default_nettype wire

FILE: test/delta_list_sleep_timer_core_tb.sv
// Testbench for delta_list_sleep_timer_core: drives ticks and sleep inserts,
// predicts every result with a delta-list model and checks each one in order.
// Depends on dlst_pkg and the core RTL only.
`default_nettype none
module delta_list_sleep_timer_core_tb;
    import dlst_pkg::*;

    localparam int NSLOT = 16;
    localparam int NIL = NSLOT;
    localparam longint CYCLE_LIMIT = 2000000;

    // Sleep timer predictor with its own copy of the slot store and clock.
    class sleep_scoreboard;
        t_out_item pending_results[$];
        logic [15:0] wait_delta[NSLOT];
        logic [7:0] sleeper[NSLOT];
        int next_slot[NSLOT];
        int sleep_head;
        int spare_head;
        int prescale;
        int tps;
        int hh, mm, ss;
        int errors;

        function void clear();
            pending_results.delete();
            for (int i = 0; i < NSLOT; i++) begin
                wait_delta[i] = '0;
                sleeper[i] = '0;
                next_slot[i] = i + 1;
            end
            sleep_head = NIL;
            spare_head = 0;
            prescale = 0;
            tps = 60;
            hh = 0;
            mm = 0;
            ss = 0;
            errors = 0;
        endfunction

        function void set_rate(logic [9:0] value);
            tps = value;
        endfunction

        function void push_result(t_kind k, logic [7:0] pid, logic lst);
            t_out_item r;
            r.kind = k;
            r.process_id = pid;
            r.hours = hh[4:0];
            r.minutes = mm[5:0];
            r.seconds = ss[5:0];
            r.last = lst;
            pending_results.push_back(r);
        endfunction

        // Note an accepted input transaction and queue what it must produce.
        function void note_item(t_in_item it);
            int slot, prev, walk, rem, n, s;
            if (it.operation == OP_INSERT) begin
                slot = spare_head;
                if (slot >= NSLOT) begin
                    push_result(KIND_REJECT, it.requester_id, 1'b1);
                    return;
                end
                spare_head = next_slot[slot];
                prev = NIL;
                walk = sleep_head;
                rem = it.sleep_seconds;
                while (walk < NSLOT && rem >= wait_delta[walk]) begin
                    rem -= wait_delta[walk];
                    prev = walk;
                    walk = next_slot[walk];
                end
                if (walk < NSLOT)
                    wait_delta[walk] = wait_delta[walk] - rem[15:0];
                wait_delta[slot] = rem[15:0];
                sleeper[slot] = it.requester_id;
                next_slot[slot] = walk;
                if (prev == NIL)
                    sleep_head = slot;
                else
                    next_slot[prev] = slot;
                push_result(KIND_ACCEPT, it.requester_id, 1'b1);
                return;
            end
            // A rate of zero acts like one: every tick completes a second.
            if (prescale + 1 < tps) begin
                prescale++;
                push_result(KIND_TIME, 8'd0, 1'b1);
                return;
            end
            prescale = 0;
            ss++;
            if (ss >= 60) begin
                ss = 0;
                mm++;
                if (mm >= 60) begin
                    mm = 0;
                    hh = (hh + 1) % 24;
                end
            end
            if (sleep_head < NSLOT) begin
                if (wait_delta[sleep_head] > 0)
                    wait_delta[sleep_head]--;
                n = 0;
                while (sleep_head < NSLOT && n < NSLOT && wait_delta[sleep_head] == 0) begin
                    s = sleep_head;
                    push_result(KIND_WAKE, sleeper[s], 1'b0);
                    n++;
                    sleep_head = next_slot[s];
                    next_slot[s] = spare_head;
                    spare_head = s;
                end
            end
            push_result(KIND_TIME, 8'd0, 1'b1);
        endfunction

        // Compare one accepted result transaction with the oldest expectation.
        function void check_result(t_out_item got);
            t_out_item want;
            if (pending_results.size() == 0) begin
                $display("%0t: unexpected result, expected none, actual %h", $time, got);
                errors++;
                return;
            end
            want = pending_results.pop_front();
            if (got.kind !== want.kind) begin
                $display("%0t: kind expected %0d actual %0d", $time, want.kind, got.kind);
                errors++;
            end
            if (got.process_id !== want.process_id) begin
                $display("%0t: process_id expected %0d actual %0d", $time,
                    want.process_id, got.process_id);
                errors++;
            end
            if (got.hours !== want.hours) begin
                $display("%0t: hours expected %0d actual %0d", $time, want.hours, got.hours);
                errors++;
            end
            if (got.minutes !== want.minutes) begin
                $display("%0t: minutes expected %0d actual %0d", $time,
                    want.minutes, got.minutes);
                errors++;
            end
            if (got.seconds !== want.seconds) begin
                $display("%0t: seconds expected %0d actual %0d", $time,
                    want.seconds, got.seconds);
                errors++;
            end
            if (got.last !== want.last) begin
                $display("%0t: last expected %0d actual %0d", $time, want.last, got.last);
                errors++;
            end
        endfunction
    endclass

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    logic i_cfg_valid = 1'b0;
    logic o_cfg_ready;
    logic [9:0] i_cfg_data = '0;
    logic i_valid = 1'b0;
    logic o_ready;
    t_in_item i_data = '0;
    logic o_valid;
    logic i_ready = 1'b0;
    t_out_item o_data;

    sleep_scoreboard timer_sb;
    longint cycle_count = 0;
    // Percent chance of idling on each side; zero during the calm stretch.
    int idle_pct = 24;
    int leftover;

    delta_list_sleep_timer_core #(.MAX_SLEEPERS(NSLOT)) uut (
        .i_clk(i_clk),
        .i_rst_n(i_rst_n),
        .i_cfg_valid(i_cfg_valid),
        .o_cfg_ready(o_cfg_ready),
        .i_cfg_data(i_cfg_data),
        .i_valid(i_valid),
        .o_ready(o_ready),
        .i_data(i_data),
        .o_valid(o_valid),
        .i_ready(i_ready),
        .o_data(o_data)
    );

    always #6 i_clk = ~i_clk;

    // Result side: random stalls, and each accepted transaction is checked.
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("delta_list_sleep_timer_core_tb NOT OK");
            $finish;
        end
        if (i_rst_n && o_valid && i_ready)
            timer_sb.check_result(o_data);
        if (!i_rst_n)
            i_ready <= 1'b0;
        else
            i_ready <= ($urandom_range(99) >= idle_pct);
    end

    // Send one input transaction, with a random gap before it, and note it
    // for prediction once the block takes it. Valid drops only in a gap, so
    // back-to-back transactions keep it high.
    task automatic send_item(t_in_item it);
        while ($urandom_range(99) < idle_pct) begin
            i_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_valid <= 1'b1;
        i_data <= it;
        @(posedge i_clk);
        while (!o_ready)
            @(posedge i_clk);
        timer_sb.note_item(it);
    endtask

    task automatic send_tick();
        t_in_item it;
        it.operation = OP_TICK;
        it.requester_id = 8'($urandom);
        it.sleep_seconds = 16'($urandom);
        send_item(it);
    endtask

    task automatic send_insert(logic [7:0] pid, logic [15:0] secs);
        t_in_item it;
        it.operation = OP_INSERT;
        it.requester_id = pid;
        it.sleep_seconds = secs;
        send_item(it);
    endtask

    // Wait until every expected result is in and the block has settled,
    // then change the ticks-per-second register.
    task automatic write_rate(logic [9:0] value);
        i_valid <= 1'b0;
        while (timer_sb.pending_results.size() != 0)
            @(posedge i_clk);
        repeat (NSLOT + 8) @(posedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_data <= value;
        @(posedge i_clk);
        while (!o_cfg_ready)
            @(posedge i_clk);
        timer_sb.set_rate(value);
        i_cfg_valid <= 1'b0;
    endtask

    // Random traffic: mostly ticks to count sleeps down, inserts with short sleeps
    // so that wakeups come often, and some long sleeps and extremes.
    task automatic random_phase(int count);
        int pick;
        for (int i = 0; i < count; i++) begin
            pick = $urandom_range(99);
            if (pick < 55)
                send_tick();
            else if (pick < 85)
                send_insert(8'($urandom), 16'($urandom_range(6)));
            else if (pick < 95)
                send_insert(8'($urandom), 16'($urandom));
            else
                send_insert(8'($urandom), 16'hFFFF);
        end
    endtask

    initial begin
        timer_sb = new();
        timer_sb.clear();
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed: with one tick per second, fill the queue with equal and
        // extreme wake times, overflow it, then count them down.
        write_rate(10'd1);
        send_insert(8'h00, 16'd0);
        send_insert(8'hFF, 16'd2);
        send_insert(8'hAA, 16'd2);
        send_insert(8'h55, 16'd1);
        send_insert(8'h0F, 16'hFFFF);
        for (int i = 0; i < 11; i++)
            send_insert(8'(i + 16), 16'd3);
        send_insert(8'hF0, 16'd1);
        for (int i = 0; i < 4; i++)
            send_tick();

        // Zero rate behaves like one; a high rate of 1000 leaves the second unfinished.
        write_rate(10'd0);
        send_tick();
        send_tick();
        write_rate(10'd1000);
        send_tick();
        send_insert(8'h12, 16'd5);

        // Calm stretch with no idling at one tick per second.
        write_rate(10'd1);
        idle_pct = 0;
        random_phase(20);
        idle_pct = 24;
        random_phase(25);

        // Slower prescaler, with the reset rate as well.
        write_rate(10'd2);
        random_phase(15);
        write_rate(10'd60);
        random_phase(10);
        // Run the clock across a minute rollover on a fast rate.
        write_rate(10'd1);
        for (int i = 0; i < 60; i++)
            send_tick();

        i_valid <= 1'b0;
        while (timer_sb.pending_results.size() != 0)
            @(posedge i_clk);
        repeat (NSLOT + 8) @(posedge i_clk);
        leftover = timer_sb.pending_results.size();
        if (timer_sb.errors == 0 && leftover == 0)
            $display("delta_list_sleep_timer_core_tb OK");
        else
            $display("delta_list_sleep_timer_core_tb NOT OK");
        $finish;
    end
endmodule
`default_nettype wire
